// ===== design/assert_macros.svh =====
// Assertion macros shared by the local window entropy RTL.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LWE_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LWE_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lwe_pkg.sv =====
// Shared types, constants and the log2 table of the local window entropy block.
// No dependencies.
package lwe_pkg;

    localparam int PIX_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MIN_DIM    = 3;
    localparam int WIN_RADIUS = 2;
    localparam int WIN_ROWS   = 5;
    localparam int WIN_MAX    = 25;
    localparam int CNT_W      = 5;
    localparam int LOG_W      = 31;
    localparam int ACC_W      = 36;
    localparam int DIV_W      = 37;
    localparam int Q_W        = 15;
    localparam int ROUND_SHIFT = 15;
    localparam int DEN_SHIFT  = 16 + Q_W - 1;
    localparam int ENT_MAX    = 19022;
    localparam int SLOT_W     = 3;
    localparam int STEP_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_DEEP_PIXELS  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [CNT_W-1:0] n;
    } div_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quot;
    } div_rsp_t;

    // log2(c) in unsigned Q3.28, rounded to nearest
    function automatic logic [LOG_W-1:0] log2_q28(input logic [CNT_W-1:0] c);
        logic [LOG_W-1:0] v;
        case (c)
            5'd2:    v = 31'd268435456;
            5'd3:    v = 31'd425460132;
            5'd4:    v = 31'd536870912;
            5'd5:    v = 31'd623287827;
            5'd6:    v = 31'd693895588;
            5'd7:    v = 31'd753593599;
            5'd8:    v = 31'd805306368;
            5'd9:    v = 31'd850920263;
            5'd10:   v = 31'd891723283;
            5'd11:   v = 31'd928634104;
            5'd12:   v = 31'd962331044;
            5'd13:   v = 31'd993329223;
            5'd14:   v = 31'd1022029055;
            5'd15:   v = 31'd1048747959;
            5'd16:   v = 31'd1073741824;
            5'd17:   v = 31'd1097219952;
            5'd18:   v = 31'd1119355719;
            5'd19:   v = 31'd1140294359;
            5'd20:   v = 31'd1160158739;
            5'd21:   v = 31'd1179053730;
            5'd22:   v = 31'd1197069560;
            5'd23:   v = 31'd1214284416;
            5'd24:   v = 31'd1230766500;
            5'd25:   v = 31'd1246575654;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/lwe_line_mem.sv =====
// Five-row line store: one write port, one read port with registered data.
// Depends on lwe_pkg.
module lwe_line_mem #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                              clk,
    input  logic                                              wr_en,
    input  logic [$clog2(lwe_pkg::WIN_ROWS*MAX_WIDTH)-1:0]    wr_addr,
    input  logic [lwe_pkg::PIX_W-1:0]                         wr_data,
    input  logic                                              rd_en,
    input  logic [$clog2(lwe_pkg::WIN_ROWS*MAX_WIDTH)-1:0]    rd_addr,
    output logic [lwe_pkg::PIX_W-1:0]                         rd_data
);

    localparam int DEPTH = lwe_pkg::WIN_ROWS * MAX_WIDTH;

    logic [lwe_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/lwe_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the entropy normalization.
// Depends on lwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lwe_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  lwe_pkg::div_req_t req,
    output lwe_pkg::div_rsp_t rsp
);

    logic [lwe_pkg::DIV_W-1:0]  rem_reg;
    logic [lwe_pkg::DIV_W-1:0]  den_reg;
    logic [lwe_pkg::Q_W-1:0]    quot_reg;
    logic [lwe_pkg::STEP_W-1:0] step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       ge;

    assign ge = (rem_reg >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= lwe_pkg::STEP_W'(lwe_pkg::Q_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            den_reg  <= lwe_pkg::DIV_W'(req.n) << lwe_pkg::DEN_SHIFT;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            den_reg  <= den_reg >> 1;
            quot_reg <= {quot_reg[lwe_pkg::Q_W-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `LWE_CHECK_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg, "divider did not start")
    `LWE_CHECK(a_done_idle, clk, rst_n, done_reg, !busy_reg, "divider done while busy")

endmodule

// ===== design/local_window_entropy.sv =====
// Local window entropy, top level: position tracking, window walk and counting.
// Depends on lwe_pkg, lwe_line_mem, lwe_divider and assert_macros.svh.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_ready with pixel.
//   For each pixel whose 5x5 window (clipped at the borders) is complete,
//   one result beat leaves on out_valid/out_ready: center_row, center_col,
//   entropy_q12 (Q3.12), last_of_run on the final beat released by a pixel,
//   frame_done on the beat for the image's last pixel. A pixel releases
//   0 to 9 beats. The cfg channel (cfg_index, cfg_data) writes image_width,
//   image_height, deep_pixels; any write restarts the frame.
//   Each result is set up, reads its n values (n the window size, up to 25)
//   through the single line store read port, counts them one element per
//   step, sums, and then runs the 15 steps of the quotient divider. A
//   window of one value skips the divider.
//   in_ready and cfg_ready are high only between pixels; in_ready drops while
//   a cfg beat is offered.
//   Reset returns geometry to 96 x 96, 8-bit mode and the frame start; the
//   line store needs no clearing. A stalled receiver holds the output
//   register; work on the next result goes on until it needs that register.
`include "assert_macros.svh"

module local_window_entropy #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lwe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lwe_pkg::PIX_W-1:0]       pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      center_row,
    output logic [7:0]                      center_col,
    output logic [lwe_pkg::Q_W-1:0]         entropy_q12,
    output logic                            last_of_run,
    output logic                            frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(lwe_pkg::WIN_ROWS * MAX_WIDTH);
    localparam int SW  = lwe_pkg::SLOT_W;
    localparam int NW  = lwe_pkg::CNT_W;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SETUP  = 9'b000000010,
        ST_GATHER = 9'b000000100,
        ST_DRAIN  = 9'b000001000,
        ST_COUNT  = 9'b000010000,
        ST_SUM    = 9'b000100000,
        ST_PREP   = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [lwe_pkg::CFG_DATA_W-1:0] width_cfg_reg;
    logic [lwe_pkg::CFG_DATA_W-1:0] height_cfg_reg;
    logic                           deep_reg;
    logic [WDW-1:0]                 w_eff;
    logic [HDW-1:0]                 h_eff;
    logic [CW-1:0]                  wl;
    logic [RW-1:0]                  hl;

    logic [RW-1:0] row_pos_reg;
    logic [CW-1:0] col_pos_reg;
    logic [SW-1:0] slot_pos_reg;

    logic [RW-1:0] pr_reg;
    logic [SW-1:0] pslot_reg;
    logic [RW-1:0] y1_reg, ycur_reg;
    logic [CW-1:0] x0_reg, x1_reg, xcur_reg;

    logic [RW-1:0] rr_reg, r1_reg;
    logic [CW-1:0] cc_reg, c0_reg, c1_reg;
    logic [SW-1:0] rslot_reg;

    logic [lwe_pkg::PIX_W-1:0] vals [lwe_pkg::WIN_MAX];
    logic [NW-1:0]             n_reg;
    logic [NW-1:0]             i_reg;
    logic                      rd_pend_reg;
    logic [NW-1:0]             cnt_reg;
    logic                      cnt_vld_reg;
    logic [lwe_pkg::ACC_W-1:0] plog_reg;
    logic [lwe_pkg::ACC_W-1:0] total_reg;
    logic [lwe_pkg::Q_W-1:0]   ent_reg;

    logic                      out_valid_reg;
    logic [7:0]                center_row_reg;
    logic [7:0]                center_col_reg;
    logic [lwe_pkg::Q_W-1:0]   entropy_reg;
    logic                      last_reg;
    logic                      frame_reg;

    logic                      in_fire;
    logic                      cfg_fire;
    logic                      y_has, x_has;
    logic [RW-1:0]             y0_c, y1_c, r0_c, r1_c;
    logic [CW-1:0]             x0_c, x1_c, c0_c, c1_c;
    logic [SW-1:0]             d_c, rslot_c;
    logic [AW-1:0]             wr_addr, rd_addr;
    logic                      rd_en;
    logic [lwe_pkg::PIX_W-1:0] rd_data;
    logic [lwe_pkg::PIX_W-1:0] rd_masked;
    logic [lwe_pkg::WIN_MAX-1:0] match;
    logic [lwe_pkg::PIX_W-1:0] cur_val;
    logic                      emit_load;
    logic                      run_last;
    lwe_pkg::div_req_t         div_req;
    lwe_pkg::div_rsp_t         div_rsp;

    // geometry saturation
    always_comb
    begin
        if (width_cfg_reg < lwe_pkg::CFG_DATA_W'(lwe_pkg::MIN_DIM))
            w_eff = WDW'(lwe_pkg::MIN_DIM);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            w_eff = WDW'(MAX_WIDTH);
        else
            w_eff = WDW'(width_cfg_reg);
        if (height_cfg_reg < lwe_pkg::CFG_DATA_W'(lwe_pkg::MIN_DIM))
            h_eff = HDW'(lwe_pkg::MIN_DIM);
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            h_eff = HDW'(MAX_HEIGHT);
        else
            h_eff = HDW'(height_cfg_reg);
    end

    assign wl = CW'(w_eff - 1'b1);
    assign hl = RW'(h_eff - 1'b1);

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // result centers released by the incoming pixel
    always_comb
    begin
        y_has = 1'b1;
        if (row_pos_reg == hl)
        begin
            y0_c = (row_pos_reg >= RW'(lwe_pkg::WIN_RADIUS)) ?
                   row_pos_reg - RW'(lwe_pkg::WIN_RADIUS) : '0;
            y1_c = row_pos_reg;
        end
        else if (row_pos_reg >= RW'(lwe_pkg::WIN_RADIUS))
        begin
            y0_c = row_pos_reg - RW'(lwe_pkg::WIN_RADIUS);
            y1_c = y0_c;
        end
        else
        begin
            y_has = 1'b0;
            y0_c  = '0;
            y1_c  = '0;
        end
        x_has = 1'b1;
        if (col_pos_reg == wl)
        begin
            x0_c = (col_pos_reg >= CW'(lwe_pkg::WIN_RADIUS)) ?
                   col_pos_reg - CW'(lwe_pkg::WIN_RADIUS) : '0;
            x1_c = col_pos_reg;
        end
        else if (col_pos_reg >= CW'(lwe_pkg::WIN_RADIUS))
        begin
            x0_c = col_pos_reg - CW'(lwe_pkg::WIN_RADIUS);
            x1_c = x0_c;
        end
        else
        begin
            x_has = 1'b0;
            x0_c  = '0;
            x1_c  = '0;
        end
    end

    // clipped window of the current center
    always_comb
    begin
        r0_c = (ycur_reg >= RW'(lwe_pkg::WIN_RADIUS)) ?
               ycur_reg - RW'(lwe_pkg::WIN_RADIUS) : '0;
        r1_c = ((hl - ycur_reg) >= RW'(lwe_pkg::WIN_RADIUS)) ?
               ycur_reg + RW'(lwe_pkg::WIN_RADIUS) : hl;
        c0_c = (xcur_reg >= CW'(lwe_pkg::WIN_RADIUS)) ?
               xcur_reg - CW'(lwe_pkg::WIN_RADIUS) : '0;
        c1_c = ((wl - xcur_reg) >= CW'(lwe_pkg::WIN_RADIUS)) ?
               xcur_reg + CW'(lwe_pkg::WIN_RADIUS) : wl;
        d_c  = SW'(pr_reg - r0_c);
        rslot_c = (pslot_reg >= d_c) ? pslot_reg - d_c :
                  SW'(4'(pslot_reg) + 4'(lwe_pkg::WIN_ROWS) - 4'(d_c));
    end

    assign wr_addr = AW'(int'(slot_pos_reg) * MAX_WIDTH + int'(col_pos_reg));
    assign rd_addr = AW'(int'(rslot_reg) * MAX_WIDTH + int'(cc_reg));
    assign rd_en   = (state_reg == ST_GATHER);

    lwe_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wr_addr),
        .wr_data (pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_masked = deep_reg ? rd_data : {4'b0000, rd_data[7:0]};

    assign cur_val = vals[i_reg];
    always_comb
    begin
        for (int j = 0; j < lwe_pkg::WIN_MAX; j++)
        begin
            match[j] = (NW'(j) < n_reg) && (vals[j] == cur_val);
        end
    end

    assign div_req.start = (state_reg == ST_PREP) && (plog_reg < total_reg);
    assign div_req.num   = lwe_pkg::DIV_W'(total_reg - plog_reg)
                         + (lwe_pkg::DIV_W'(n_reg) << lwe_pkg::ROUND_SHIFT);
    assign div_req.n     = n_reg;

    lwe_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign run_last  = (ycur_reg == y1_reg) && (xcur_reg == x1_reg);

    // configuration and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= lwe_pkg::CFG_DATA_W'(96);
            height_cfg_reg <= lwe_pkg::CFG_DATA_W'(96);
            deep_reg       <= 1'b0;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            slot_pos_reg   <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                lwe_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                lwe_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                lwe_pkg::REG_DEEP_PIXELS:  deep_reg       <= cfg_data[0];
                default: ;
            endcase
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            slot_pos_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_pos_reg == wl)
            begin
                col_pos_reg <= '0;
                if (row_pos_reg == hl)
                begin
                    row_pos_reg  <= '0;
                    slot_pos_reg <= '0;
                end
                else
                begin
                    row_pos_reg  <= row_pos_reg + 1'b1;
                    slot_pos_reg <= (slot_pos_reg == SW'(lwe_pkg::WIN_ROWS - 1)) ?
                                    '0 : slot_pos_reg + 1'b1;
                end
            end
            else
            begin
                col_pos_reg <= col_pos_reg + 1'b1;
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            cnt_vld_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && y_has && x_has)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    state_reg <= ST_GATHER;
                end
                ST_GATHER:
                begin
                    if (cc_reg == c1_reg && rr_reg == r1_reg)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    cnt_vld_reg <= 1'b0;
                    state_reg   <= ST_COUNT;
                end
                ST_COUNT:
                begin
                    cnt_vld_reg <= 1'b1;
                    if (i_reg == n_reg - 1'b1)
                        state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    cnt_vld_reg <= 1'b0;
                    state_reg   <= ST_PREP;
                end
                ST_PREP:
                begin
                    state_reg <= div_req.start ? ST_DIV : ST_EMIT;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_load)
                        state_reg <= run_last ? ST_IDLE : ST_SETUP;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pr_reg    <= row_pos_reg;
            pslot_reg <= slot_pos_reg;
            y1_reg    <= y1_c;
            x0_reg    <= x0_c;
            x1_reg    <= x1_c;
            ycur_reg  <= y0_c;
            xcur_reg  <= x0_c;
        end
        if (state_reg == ST_SETUP)
        begin
            rr_reg    <= r0_c;
            r1_reg    <= r1_c;
            cc_reg    <= c0_c;
            c0_reg    <= c0_c;
            c1_reg    <= c1_c;
            rslot_reg <= rslot_c;
            n_reg     <= '0;
            plog_reg  <= '0;
        end
        if (state_reg == ST_GATHER)
        begin
            if (cc_reg == c1_reg)
            begin
                cc_reg    <= c0_reg;
                rr_reg    <= rr_reg + 1'b1;
                rslot_reg <= (rslot_reg == SW'(lwe_pkg::WIN_ROWS - 1)) ?
                             '0 : rslot_reg + 1'b1;
            end
            else
            begin
                cc_reg <= cc_reg + 1'b1;
            end
        end
        if (rd_pend_reg)
        begin
            vals[n_reg] <= rd_masked;
            n_reg       <= n_reg + 1'b1;
        end
        if (state_reg == ST_DRAIN)
        begin
            i_reg <= '0;
        end
        if (state_reg == ST_COUNT)
        begin
            cnt_reg <= NW'($countones(match));
            i_reg   <= i_reg + 1'b1;
        end
        if ((state_reg == ST_COUNT || state_reg == ST_SUM) && cnt_vld_reg)
        begin
            plog_reg <= plog_reg + lwe_pkg::ACC_W'(lwe_pkg::log2_q28(cnt_reg));
        end
        if (state_reg == ST_SUM)
        begin
            total_reg <= lwe_pkg::ACC_W'(n_reg) * lwe_pkg::ACC_W'(lwe_pkg::log2_q28(n_reg));
        end
        if (state_reg == ST_PREP && !div_req.start)
        begin
            ent_reg <= '0;
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            ent_reg <= div_rsp.quot;
        end
        if (emit_load && !run_last)
        begin
            if (xcur_reg == x1_reg)
            begin
                xcur_reg <= x0_reg;
                ycur_reg <= ycur_reg + 1'b1;
            end
            else
            begin
                xcur_reg <= xcur_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            center_row_reg <= 8'(32'(ycur_reg));
            center_col_reg <= 8'(32'(xcur_reg));
            entropy_reg    <= ent_reg;
            last_reg       <= run_last;
            frame_reg      <= (ycur_reg == hl) && (xcur_reg == wl);
        end
    end

    assign out_valid   = out_valid_reg;
    assign center_row  = center_row_reg;
    assign center_col  = center_col_reg;
    assign entropy_q12 = entropy_reg;
    assign last_of_run = last_reg;
    assign frame_done  = frame_reg;

    `LWE_CHECK(a_idle_no_read, clk, rst_n, state_reg == ST_IDLE, !rd_pend_reg, "read in flight while idle")
    `LWE_CHECK(a_prep_count, clk, rst_n, state_reg == ST_PREP, (n_reg != '0) && (n_reg <= NW'(lwe_pkg::WIN_MAX)), "window size out of range")
    `LWE_CHECK(a_ent_range, clk, rst_n, emit_load, ent_reg <= lwe_pkg::Q_W'(lwe_pkg::ENT_MAX), "entropy above maximum")
    `LWE_CHECK(a_div_owned, clk, rst_n, div_rsp.busy, state_reg == ST_DIV, "divider busy outside divide state")

endmodule
